// File: hw/rtl/hcri_pkg.sv
package hcri_pkg;

	// request codes
	localparam logic [1:0] OP_HEAT = 2'd0;
	localparam logic [1:0] OP_COOL = 2'd1;
	localparam logic [1:0] OP_IDLE = 2'd2;

	// operating modes
	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_HEAT = 2'd1;
	localparam logic [1:0] MODE_COOL = 2'd2;

	localparam int TIME_W   = 32;
	localparam int LIMIT_W  = 24;
	localparam int CIDX_W   = 8;
	localparam int CDATA_W  = 32;

	// register indexes
	localparam logic [CIDX_W-1:0] REG_MIN_HEAT   = 8'd0;
	localparam logic [CIDX_W-1:0] REG_MAX_HEAT   = 8'd1;
	localparam logic [CIDX_W-1:0] REG_MIN_COOL   = 8'd2;
	localparam logic [CIDX_W-1:0] REG_MAX_COOL   = 8'd3;
	localparam logic [CIDX_W-1:0] REG_HEAT_GAP   = 8'd4;
	localparam logic [CIDX_W-1:0] REG_COOL_GAP   = 8'd5;
	localparam logic [CIDX_W-1:0] REG_H2C_GAP    = 8'd6;
	localparam logic [CIDX_W-1:0] REG_C2H_GAP    = 8'd7;

	// reset values
	localparam logic [LIMIT_W-1:0] RST_MIN_TIME = 24'd60;
	localparam logic [LIMIT_W-1:0] RST_MAX_TIME = 24'd3600;
	localparam logic [LIMIT_W-1:0] RST_GAP      = 24'd300;

	typedef struct packed {
		logic [1:0]        op;
		logic [TIME_W-1:0] now_seconds;
	} req_t;

	typedef struct packed {
		logic [1:0]        mode;
		logic              heat_relay;
		logic              cool_relay;
		logic [TIME_W-1:0] heat_runtime_total;
		logic [TIME_W-1:0] cool_runtime_total;
	} rsp_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] heat_min_on;
		logic [LIMIT_W-1:0] heat_max_on;
		logic [LIMIT_W-1:0] cool_min_on;
		logic [LIMIT_W-1:0] cool_max_on;
		logic [LIMIT_W-1:0] heat_off_to_on_gap;
		logic [LIMIT_W-1:0] cool_off_to_on_gap;
		logic [LIMIT_W-1:0] heat_to_cool_gap;
		logic [LIMIT_W-1:0] cool_to_heat_gap;
	} cfg_t;

endpackage

// File: hw/rtl/hcri_regs.sv
module hcri_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr,
	input  logic [hcri_pkg::CIDX_W-1:0]  index,
	input  logic [hcri_pkg::CDATA_W-1:0] data,
	output hcri_pkg::cfg_t              cfg
);
	import hcri_pkg::*;

	cfg_t cfg_q;
	logic [LIMIT_W-1:0] val;

	assign val = data[LIMIT_W-1:0];
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.heat_min_on        <= RST_MIN_TIME;
			cfg_q.heat_max_on        <= RST_MAX_TIME;
			cfg_q.cool_min_on        <= RST_MIN_TIME;
			cfg_q.cool_max_on        <= RST_MAX_TIME;
			cfg_q.heat_off_to_on_gap <= RST_GAP;
			cfg_q.cool_off_to_on_gap <= RST_GAP;
			cfg_q.heat_to_cool_gap   <= RST_GAP;
			cfg_q.cool_to_heat_gap   <= RST_GAP;
		end else if (wr) begin
			case (index)
				REG_MIN_HEAT: cfg_q.heat_min_on        <= val;
				REG_MAX_HEAT: cfg_q.heat_max_on        <= val;
				REG_MIN_COOL: cfg_q.cool_min_on        <= val;
				REG_MAX_COOL: cfg_q.cool_max_on        <= val;
				REG_HEAT_GAP: cfg_q.heat_off_to_on_gap <= val;
				REG_COOL_GAP: cfg_q.cool_off_to_on_gap <= val;
				REG_H2C_GAP:  cfg_q.heat_to_cool_gap   <= val;
				REG_C2H_GAP:  cfg_q.cool_to_heat_gap   <= val;
				default: ;
			endcase
		end
	end

endmodule

// File: hw/rtl/hcri_ctrl.sv
module hcri_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  hcri_pkg::req_t req,
	input  hcri_pkg::cfg_t cfg,
	output hcri_pkg::rsp_t rsp
);
	import hcri_pkg::*;

	logic [1:0]        mode_q;
	logic [TIME_W-1:0] heat_on_q, heat_off_q, cool_on_q, cool_off_q;
	logic [TIME_W-1:0] heat_acc_q, cool_acc_q;

	logic [TIME_W-1:0] e_hon, e_hoff, e_con, e_coff;
	logic [TIME_W-1:0] heat_total, cool_total;
	logic              is_heat, is_cool, is_idle;
	logic              stop_heat, stop_cool, start_heat, start_cool;
	logic [1:0]        mode_nxt;

	always_comb begin
		e_hon  = req.now_seconds - heat_on_q;
		e_hoff = req.now_seconds - heat_off_q;
		e_con  = req.now_seconds - cool_on_q;
		e_coff = req.now_seconds - cool_off_q;

		is_heat = (mode_q == MODE_HEAT);
		is_cool = (mode_q == MODE_COOL);
		is_idle = (mode_q == MODE_IDLE);

		// a heat request stops heating only once past the max on time
		stop_heat = is_heat && (e_hon > {8'd0, cfg.heat_min_on}) &&
			((req.op == OP_COOL) || (req.op == OP_IDLE) ||
			 ((req.op == OP_HEAT) && (e_hon > {8'd0, cfg.heat_max_on})));
		stop_cool = is_cool && (e_con > {8'd0, cfg.cool_min_on}) &&
			((req.op == OP_HEAT) || (req.op == OP_IDLE) ||
			 ((req.op == OP_COOL) && (e_con > {8'd0, cfg.cool_max_on})));

		// changeover in the same beat never starts: a start needs idle mode, a stop needs heat or cool
		start_heat = is_idle && (req.op == OP_HEAT) &&
			(e_hoff > {8'd0, cfg.heat_off_to_on_gap}) &&
			(e_coff > {8'd0, cfg.cool_to_heat_gap});
		start_cool = is_idle && (req.op == OP_COOL) &&
			(e_coff > {8'd0, cfg.cool_off_to_on_gap}) &&
			(e_hoff > {8'd0, cfg.heat_to_cool_gap});

		if (stop_heat || stop_cool)
			mode_nxt = MODE_IDLE;
		else if (start_heat)
			mode_nxt = MODE_HEAT;
		else if (start_cool)
			mode_nxt = MODE_COOL;
		else
			mode_nxt = mode_q;

		// same sum whether the run continues or ends this beat
		heat_total = is_heat ? heat_acc_q + e_hon : heat_acc_q;
		cool_total = is_cool ? cool_acc_q + e_con : cool_acc_q;

		rsp.mode               = mode_nxt;
		rsp.heat_relay         = (mode_nxt == MODE_HEAT);
		rsp.cool_relay         = (mode_nxt == MODE_COOL);
		rsp.heat_runtime_total = heat_total;
		rsp.cool_runtime_total = cool_total;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			heat_on_q  <= '0;
			heat_off_q <= '0;
			cool_on_q  <= '0;
			cool_off_q <= '0;
			heat_acc_q <= '0;
			cool_acc_q <= '0;
		end else if (step) begin
			mode_q <= mode_nxt;
			if (start_heat)
				heat_on_q <= req.now_seconds;
			if (start_cool)
				cool_on_q <= req.now_seconds;
			if (stop_heat) begin
				heat_off_q <= req.now_seconds;
				heat_acc_q <= heat_total;
			end
			if (stop_cool) begin
				cool_off_q <= req.now_seconds;
				cool_acc_q <= cool_total;
			end
		end
	end

endmodule

// File: hw/rtl/heat_cool_relay_interlock.sv
// channel  | handshake             | payload
// ---------+-----------------------+---------------------------------
// req      | req_valid / req_ready | req  : op, now_seconds
// rsp      | rsp_valid / rsp_ready | rsp  : mode, relays, runtime totals
// cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data (low 24 bits)
//
// One beat per cycle sustained while rsp_ready stays high; a request's result reaches rsp through
// the input register, then the state update and result register.
// The mode/stamp state advances as the input register moves into the result register.
// Reset: idle, all stamps and totals zero, limits at defaults. cfg_ready is always high.
// A stalled rsp holds the input register; req_ready drops only when both stages are full.
module heat_cool_relay_interlock (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  hcri_pkg::req_t               req,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output hcri_pkg::rsp_t               rsp,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [hcri_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [hcri_pkg::CDATA_W-1:0] cfg_data
);
	import hcri_pkg::*;

	cfg_t cfg;
	req_t req_s1;
	logic valid_s1;
	rsp_t rsp_nxt;
	rsp_t rsp_s2;
	logic valid_s2;
	logic adv;

	assign cfg_ready = 1'b1;
	assign adv       = valid_s1 && (!valid_s2 || rsp_ready);
	assign req_ready = !valid_s1 || adv;
	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

	hcri_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cfg_valid && cfg_ready),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	hcri_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.req    (req_s1),
		.cfg    (cfg),
		.rsp    (rsp_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req_ready)
				valid_s1 <= req_valid;
			if (adv)
				valid_s2 <= 1'b1;
			else if (rsp_ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready)
			req_s1 <= req;
		if (adv)
			rsp_s2 <= rsp_nxt;
	end

	a_relays_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.heat_relay && rsp.cool_relay))
		else $error("both relays driven");

	a_relay_matches_mode: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.heat_relay == (rsp.mode == MODE_HEAT)) &&
			(rsp.cool_relay == (rsp.mode == MODE_COOL)))
		else $error("relay drive disagrees with mode");

	a_backpressure_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> valid_s1 && valid_s2 && !rsp_ready)
		else $error("req stalled without a full pipeline");

	a_advance_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s2)
		else $error("advanced beat lost");

endmodule

// File: bench/tb_heat_cool_relay_interlock.sv
module tb_heat_cool_relay_interlock;
	timeunit 1ns;
	timeprecision 1ps;

	import hcri_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int HOLD_CYCLES  = 200;
	localparam int DIR_N        = 22;

	// op code with no meaning, must leave state untouched
	localparam logic [1:0] OP_RSVD = 2'd3;
	localparam logic [1:0] REQ_OPS [3] = '{OP_HEAT, OP_COOL, OP_IDLE};
	localparam int unsigned PHASE_SCALES [4] = '{16, 300, 5000, 24'hFFFFFF};
	localparam rsp_t NO_RSP = '0;

	typedef struct packed {
		logic [1:0]        op;
		logic [TIME_W-1:0] now_s;
		logic              pinned;
		rsp_t              rsp;
	} dir_row_t;

	// pinned rows carry a hand-computed result, the rest go through the predictor
	dir_row_t dir_tbl [DIR_N] = '{
		{OP_IDLE, 32'd0,          1'b1, MODE_IDLE, 1'b0, 1'b0, 32'd0,          32'd0},
		{OP_HEAT, 32'd300,        1'b1, MODE_IDLE, 1'b0, 1'b0, 32'd0,          32'd0},
		{OP_HEAT, 32'd301,        1'b1, MODE_HEAT, 1'b1, 1'b0, 32'd0,          32'd0},
		{OP_COOL, 32'd361,        1'b1, MODE_HEAT, 1'b1, 1'b0, 32'd60,         32'd0},
		{OP_IDLE, 32'd362,        1'b1, MODE_IDLE, 1'b0, 1'b0, 32'd61,         32'd0},
		{OP_COOL, 32'd662,        1'b1, MODE_IDLE, 1'b0, 1'b0, 32'd61,         32'd0},
		{OP_COOL, 32'd663,        1'b1, MODE_COOL, 1'b0, 1'b1, 32'd61,         32'd0},
		{OP_RSVD, 32'd700,        1'b1, MODE_COOL, 1'b0, 1'b1, 32'd61,         32'd37},
		{OP_HEAT, 32'd723,        1'b1, MODE_COOL, 1'b0, 1'b1, 32'd61,         32'd60},
		{OP_HEAT, 32'd724,        1'b1, MODE_IDLE, 1'b0, 1'b0, 32'd61,         32'd61},
		{OP_COOL, 32'd4325,       1'b1, MODE_COOL, 1'b0, 1'b1, 32'd61,         32'd61},
		{OP_COOL, 32'd7925,       1'b1, MODE_COOL, 1'b0, 1'b1, 32'd61,         32'd3661},
		{OP_COOL, 32'd7926,       1'b1, MODE_IDLE, 1'b0, 1'b0, 32'd61,         32'd3662},
		{OP_HEAT, 32'd100,        1'b1, MODE_HEAT, 1'b1, 1'b0, 32'd61,         32'd3662},
		{OP_IDLE, 32'hFFFF_FFFF,  1'b1, MODE_IDLE, 1'b0, 1'b0, 32'd4294967256, 32'd3662},
		{OP_HEAT, 32'd0,          1'b1, MODE_IDLE, 1'b0, 1'b0, 32'd4294967256, 32'd3662},
		{OP_HEAT, 32'd301,        1'b1, MODE_HEAT, 1'b1, 1'b0, 32'd4294967256, 32'd3662},
		{OP_IDLE, 32'd401,        1'b1, MODE_IDLE, 1'b0, 1'b0, 32'd60,         32'd3662},
		{OP_HEAT, 32'd702,        1'b0, NO_RSP},
		{OP_HEAT, 32'd4303,       1'b0, NO_RSP},
		{OP_RSVD, 32'hFFFF_FFFF,  1'b0, NO_RSP},
		{OP_COOL, 32'h8000_0000,  1'b0, NO_RSP}
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_ready;
	req_t               req = '0;
	logic               rsp_valid;
	logic               rsp_ready = 1'b0;
	rsp_t               rsp;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [CIDX_W-1:0]  cfg_index = '0;
	logic [CDATA_W-1:0] cfg_data = '0;

	// side band that travels with each request beat
	logic               req_pin = 1'b0;
	rsp_t               req_pin_rsp = '0;

	// predictor state
	logic [1:0]         relay_mode = MODE_IDLE;
	logic [TIME_W-1:0]  heat_on_at = '0;
	logic [TIME_W-1:0]  heat_off_at = '0;
	logic [TIME_W-1:0]  cool_on_at = '0;
	logic [TIME_W-1:0]  cool_off_at = '0;
	logic [TIME_W-1:0]  heat_run_acc = '0;
	logic [TIME_W-1:0]  cool_run_acc = '0;
	logic [LIMIT_W-1:0] lim [8] = '{RST_MIN_TIME, RST_MAX_TIME, RST_MIN_TIME, RST_MAX_TIME,
		RST_GAP, RST_GAP, RST_GAP, RST_GAP};

	rsp_t               relay_expect_q [$];
	int                 mismatches = 0;
	int                 results_seen = 0;
	int                 items_sent = 0;
	int                 cycle_count = 0;

	logic [TIME_W-1:0]  now_t = '0;
	logic [1:0]         last_op = OP_HEAT;
	bit                 req_gaps = 1'b1;
	bit                 rsp_idle_on = 1'b1;
	int                 hold_requests = 0;
	int                 hold_served = 0;
	int                 hold_left = 0;
	int                 stall_left = 0;

	heat_cool_relay_interlock u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	function automatic logic [TIME_W-1:0] since(input logic [TIME_W-1:0] now,
		input logic [TIME_W-1:0] stamp);
		return now - stamp;
	endfunction

	function automatic void end_run_if_min_met(input logic [TIME_W-1:0] now);
		if (relay_mode == MODE_HEAT) begin
			if (since(now, heat_on_at) > lim[REG_MIN_HEAT[2:0]]) begin
				heat_off_at = now;
				relay_mode = MODE_IDLE;
				heat_run_acc = heat_run_acc + since(now, heat_on_at);
			end
		end else if (relay_mode == MODE_COOL) begin
			if (since(now, cool_on_at) > lim[REG_MIN_COOL[2:0]]) begin
				cool_off_at = now;
				relay_mode = MODE_IDLE;
				cool_run_acc = cool_run_acc + since(now, cool_on_at);
			end
		end
	endfunction

	function automatic rsp_t relay_step(input req_t r);
		rsp_t o;
		logic [TIME_W-1:0] now;
		now = r.now_seconds;
		case (r.op)
			OP_HEAT: begin
				if (relay_mode == MODE_COOL)
					end_run_if_min_met(now);
				if (relay_mode == MODE_IDLE &&
					since(now, heat_off_at) > lim[REG_HEAT_GAP[2:0]] &&
					since(now, cool_off_at) > lim[REG_C2H_GAP[2:0]]) begin
					relay_mode = MODE_HEAT;
					heat_on_at = now;
				end
				if (relay_mode == MODE_HEAT &&
					since(now, heat_on_at) > lim[REG_MAX_HEAT[2:0]])
					end_run_if_min_met(now);
			end
			OP_COOL: begin
				if (relay_mode == MODE_HEAT)
					end_run_if_min_met(now);
				if (relay_mode == MODE_IDLE &&
					since(now, cool_off_at) > lim[REG_COOL_GAP[2:0]] &&
					since(now, heat_off_at) > lim[REG_H2C_GAP[2:0]]) begin
					relay_mode = MODE_COOL;
					cool_on_at = now;
				end
				if (relay_mode == MODE_COOL &&
					since(now, cool_on_at) > lim[REG_MAX_COOL[2:0]])
					end_run_if_min_met(now);
			end
			OP_IDLE: end_run_if_min_met(now);
			default: ;
		endcase
		o.mode = relay_mode;
		o.heat_relay = (relay_mode == MODE_HEAT);
		o.cool_relay = (relay_mode == MODE_COOL);
		o.heat_runtime_total = (relay_mode == MODE_HEAT) ?
			heat_run_acc + since(now, heat_on_at) : heat_run_acc;
		o.cool_runtime_total = (relay_mode == MODE_COOL) ?
			cool_run_acc + since(now, cool_on_at) : cool_run_acc;
		return o;
	endfunction

	// result check first, then prediction for the request beat of the same edge
	always @(posedge clk) begin : relay_check
		rsp_t want;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				results_seen++;
				if (relay_expect_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result %0d: mode=%0d heat_rt=%0d cool_rt=%0d",
							results_seen, rsp.mode, rsp.heat_runtime_total,
							rsp.cool_runtime_total);
				end else begin
					want = relay_expect_q.pop_front();
					if (rsp.mode !== want.mode || rsp.heat_relay !== want.heat_relay ||
						rsp.cool_relay !== want.cool_relay ||
						rsp.heat_runtime_total !== want.heat_runtime_total ||
						rsp.cool_runtime_total !== want.cool_runtime_total) begin
						mismatches++;
						// fields: mode/heat/cool/heat_rt/cool_rt
						if (mismatches <= 10)
							$display("result %0d: want %0d/%0b/%0b/%0d/%0d got %0d/%0b/%0b/%0d/%0d",
								results_seen, want.mode, want.heat_relay, want.cool_relay,
								want.heat_runtime_total, want.cool_runtime_total,
								rsp.mode, rsp.heat_relay, rsp.cool_relay,
								rsp.heat_runtime_total, rsp.cool_runtime_total);
					end
				end
			end
			if (req_valid && req_ready) begin
				want = relay_step(req);
				if (req_pin)
					want = req_pin_rsp;
				relay_expect_q.push_back(want);
			end
			if (cfg_valid && cfg_ready && cfg_index <= REG_C2H_GAP)
				lim[cfg_index[2:0]] = cfg_data[LIMIT_W-1:0];
		end
	end

	// result side back-pressure: long hold on request, short random stalls otherwise
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_ready <= 1'b0;
		end else if (hold_served != hold_requests) begin
			hold_served <= hold_requests;
			hold_left <= HOLD_CYCLES;
			rsp_ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			rsp_ready <= 1'b0;
		end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 8);
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	task automatic send_req(input logic [1:0] op, input logic [TIME_W-1:0] now,
		input logic pin, input rsp_t pin_rsp);
		req_t beat;
		beat.op = op;
		beat.now_seconds = now;
		if (req_gaps && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= beat;
		req_pin <= pin;
		req_pin_rsp <= pin_rsp;
		do @(posedge clk); while (!req_ready);
		items_sent++;
	endtask

	// mostly thermostat-like time steps around the limits, now and then a jump anywhere
	task automatic send_random(input int count, input int unsigned scale);
		int unsigned sel;
		logic [1:0] op;
		for (int n = 0; n < count; n++) begin
			sel = $urandom_range(0, 99);
			if (sel < 55)
				now_t = now_t + $urandom_range(0, scale / 8 + 2);
			else if (sel < 85)
				now_t = now_t + $urandom_range(0, 2 * scale + 2);
			else if (sel < 95)
				now_t = now_t + $urandom_range(scale, 4 * scale + 4);
			else
				now_t = $urandom;
			sel = $urandom_range(0, 99);
			if (sel < 3) begin
				op = OP_RSVD;
			end else if (sel < 30) begin
				last_op = REQ_OPS[2'($urandom_range(0, 2))];
				op = last_op;
			end else begin
				op = last_op;
			end
			send_req(op, now_t, 1'b0, NO_RSP);
		end
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		while (results_seen != items_sent) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_random_limits(input int unsigned hi);
		for (int i = REG_MIN_HEAT; i <= REG_C2H_GAP; i++)
			write_reg(8'(i), {8'($urandom), 24'($urandom_range(0, hi))});
		// stray index, must be dropped
		write_reg(8'($urandom_range(8, 255)), $urandom);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_N; i++)
			send_req(dir_tbl[i].op, dir_tbl[i].now_s, dir_tbl[i].pinned, dir_tbl[i].rsp);

		// defaults, with one long result hold while requests keep coming
		send_random(100, 300);
		hold_requests <= hold_requests + 1;
		req_gaps = 1'b0;
		send_random(40, 300);
		req_gaps = 1'b1;
		send_random(110, 300);
		drain_results();

		for (int i = REG_MIN_HEAT; i <= REG_C2H_GAP; i++)
			write_reg(8'(i), '0);
		send_random(150, 4);
		drain_results();

		// all ones: upper data bits must be masked off
		for (int i = REG_MIN_HEAT; i <= REG_C2H_GAP; i++)
			write_reg(8'(i), '1);
		write_reg(8'hFF, $urandom);
		write_reg(8'd8, $urandom);
		now_t = $urandom;
		send_random(150, 24'hFFFFFF);
		drain_results();

		foreach (PHASE_SCALES[p]) begin
			load_random_limits(PHASE_SCALES[p]);
			send_random(250, PHASE_SCALES[p]);
			drain_results();
		end

		// closing stretch at full rate, no stalls on either side
		load_random_limits(40);
		req_gaps = 1'b0;
		rsp_idle_on <= 1'b0;
		send_random(300, 40);
		drain_results();
		repeat (10) @(posedge clk);

		if (mismatches == 0 && relay_expect_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
